/* src/r2a_pkg.sv */
// r2a_pkg: shared widths, character codes, sequencer states and divider
// control structs for the radix integer to ascii core. No dependencies.
package r2a_pkg;

  // datapath sizes
  localparam int VALUE_WIDTH = 32;
  localparam int MAX_CHARS   = 33;
  localparam int CHAR_W      = 7;
  localparam int RADIX_W     = 5;
  localparam int FLAGS_W     = 2;
  localparam int DIGIT_W     = 4;
  localparam int ADDR_W      = $clog2(VALUE_WIDTH);
  localparam int STEP_W      = $clog2(VALUE_WIDTH);
  localparam int LEN_W       = $clog2(VALUE_WIDTH + MAX_CHARS + 2);

  // radix limits
  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

  // format flag bit positions
  localparam int FLAG_UNSIGNED = 0;
  localparam int FLAG_LOWER    = 1;

  // ascii codes
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE    = 7'h39;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 7'h46;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 7'h66;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_LOAD
  } r2a_state_e;

  typedef struct packed {
    logic start;  // load a new dividend
    logic cont;   // divide own quotient again
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // digit value to ascii character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic lower);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(10)) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = (lower ? CHAR_LOWER_A : CHAR_UPPER_A) + CHAR_W'(d) - CHAR_W'(10);
    end
    return c;
  endfunction

endpackage

/* src/r2a_if.sv */
// r2a_if: valid/ready channel interfaces for number items in and characters out.
// Depends on r2a_pkg for field widths.
interface r2a_in_if;
  logic                            valid;
  logic                            ready;
  logic [r2a_pkg::VALUE_WIDTH-1:0] value;
  logic [r2a_pkg::RADIX_W-1:0]     radix;
  logic [r2a_pkg::FLAGS_W-1:0]     format_flags;

  modport source (output valid, output value, output radix, output format_flags,
                  input ready);
  modport sink   (input valid, input value, input radix, input format_flags,
                  output ready);
endinterface

interface r2a_out_if;
  logic                       valid;
  logic                       ready;
  logic [r2a_pkg::CHAR_W-1:0] character;
  logic                       last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface

/* src/radix_integer_to_ascii_core.sv */
// radix_integer_to_ascii_core: top level, sequencer around the serial divider
// and the digit store. Depends on r2a_pkg, r2a_if, r2a_divider, r2a_digit_ram.
//
//   channel | dir | payload                        | handshake
//   in_i    | in  | value, radix, format_flags     | valid/ready
//   out_o   | out | character, last_char           | valid/ready
//
// each digit comes from a pass of the bit-serial divider over the running
// quotient, so a 32-bit number gives up to 10 decimal digits or 32 binary
// digits; then each digit character is read from the store (read, then load)
// and the minus sign loaded directly, either held by an output stall. one item
// is in flight; in_i.ready is high only idle.
// reset clears the sequencer and output valid; the digit store needs no clearing.
module radix_integer_to_ascii_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  r2a_in_if.sink    in_i,
  r2a_out_if.source out_o
);

  localparam int W = r2a_pkg::VALUE_WIDTH;

  r2a_pkg::r2a_state_e state_q, state_d;

  logic                          neg_q, lower_q;
  logic [r2a_pkg::RADIX_W-1:0]   base_q;
  logic [r2a_pkg::ADDR_W-1:0]    nrev_q, rd_idx_q;
  logic [r2a_pkg::LEN_W-1:0]     em_q, limit_q;
  logic                          out_valid_q;
  logic [r2a_pkg::CHAR_W-1:0]    out_char_q;
  logic                          out_last_q;

  r2a_pkg::div_ctrl_t            div_ctrl;
  r2a_pkg::div_stat_t            div_stat;
  logic [W-1:0]                  quotient;
  logic [r2a_pkg::DIGIT_W-1:0]   remainder;
  logic                          quo_zero;

  logic                          in_neg;
  logic [W-1:0]                  in_mag;
  logic [r2a_pkg::RADIX_W-1:0]   in_base;
  logic                          accept;
  logic                          out_free;
  logic                          last_w;
  logic [r2a_pkg::LEN_W-1:0]     total_w, limit_w;
  logic                          ram_we, ram_re;
  logic [r2a_pkg::CHAR_W-1:0]    ram_wdata, ram_rdata;
  logic                          load_sign, load_digit;

  // input decode: sign, magnitude, clamped radix
  assign in_neg  = !in_i.format_flags[r2a_pkg::FLAG_UNSIGNED] && in_i.value[W-1];
  assign in_mag  = in_neg ? (~in_i.value + W'(1)) : in_i.value;
  assign in_base = (in_i.radix < r2a_pkg::RADIX_MIN) ? r2a_pkg::RADIX_MIN :
                   (in_i.radix > r2a_pkg::RADIX_MAX) ? r2a_pkg::RADIX_MAX : in_i.radix;

  assign in_i.ready = (state_q == r2a_pkg::ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign quo_zero   = (quotient == '0);
  assign last_w     = (em_q + r2a_pkg::LEN_W'(1)) == limit_q;

  // text length, capped at the character limit
  assign total_w = r2a_pkg::LEN_W'(neg_q) + r2a_pkg::LEN_W'(nrev_q) + r2a_pkg::LEN_W'(1);
  assign limit_w = (total_w > r2a_pkg::LEN_W'(r2a_pkg::MAX_CHARS)) ?
                   r2a_pkg::LEN_W'(r2a_pkg::MAX_CHARS) : total_w;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      r2a_pkg::ST_IDLE: begin
        if (in_i.valid) state_d = r2a_pkg::ST_DIV;
      end
      r2a_pkg::ST_DIV: begin
        if (div_stat.done && quo_zero) begin
          state_d = neg_q ? r2a_pkg::ST_SIGN : r2a_pkg::ST_READ;
        end
      end
      r2a_pkg::ST_SIGN: begin
        if (out_free) state_d = last_w ? r2a_pkg::ST_IDLE : r2a_pkg::ST_READ;
      end
      r2a_pkg::ST_READ: begin
        state_d = r2a_pkg::ST_LOAD;
      end
      r2a_pkg::ST_LOAD: begin
        if (out_free) state_d = last_w ? r2a_pkg::ST_IDLE : r2a_pkg::ST_READ;
      end
      default: state_d = r2a_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    div_ctrl   = '0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    load_sign  = 1'b0;
    load_digit = 1'b0;
    case (state_q)
      r2a_pkg::ST_IDLE: div_ctrl.start = in_i.valid;
      r2a_pkg::ST_DIV: begin
        ram_we        = div_stat.done;
        div_ctrl.cont = div_stat.done && !quo_zero;
      end
      r2a_pkg::ST_SIGN: load_sign  = out_free;
      r2a_pkg::ST_READ: ram_re     = 1'b1;
      r2a_pkg::ST_LOAD: load_digit = out_free;
      default: ;
    endcase
  end

  assign ram_wdata = r2a_pkg::digit_char(remainder, lower_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= r2a_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_sign || load_digit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item context and counters
  always_ff @(posedge clk_i) begin
    if (accept) begin
      neg_q   <= in_neg;
      lower_q <= in_i.format_flags[r2a_pkg::FLAG_LOWER];
      base_q  <= in_base;
      nrev_q  <= '0;
      em_q    <= '0;
    end
    if (ram_we) begin
      if (!quo_zero) begin
        nrev_q <= nrev_q + r2a_pkg::ADDR_W'(1);
      end else begin
        limit_q  <= limit_w;
        rd_idx_q <= nrev_q;
      end
    end
    if (load_sign) begin
      em_q       <= em_q + r2a_pkg::LEN_W'(1);
      out_char_q <= r2a_pkg::CHAR_MINUS;
      out_last_q <= last_w;
    end
    if (load_digit) begin
      em_q       <= em_q + r2a_pkg::LEN_W'(1);
      rd_idx_q   <= rd_idx_q - r2a_pkg::ADDR_W'(1);
      out_char_q <= ram_rdata;
      out_last_q <= last_w;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.character = out_char_q;
  assign out_o.last_char = out_last_q;

  r2a_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (div_ctrl),
    .dividend_i  (in_mag),
    .base_i      (div_ctrl.start ? in_base : base_q),
    .stat_o      (div_stat),
    .quotient_o  (quotient),
    .remainder_o (remainder)
  );

  r2a_digit_ram u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (nrev_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

endmodule

/* src/r2a_divider.sv */
// r2a_divider: restoring bit-serial divide of the running quotient by the radix,
// one quotient bit per cycle. Depends on r2a_pkg.
module r2a_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  r2a_pkg::div_ctrl_t              ctrl_i,
  input  logic [r2a_pkg::VALUE_WIDTH-1:0] dividend_i,
  input  logic [r2a_pkg::RADIX_W-1:0]     base_i,
  output r2a_pkg::div_stat_t              stat_o,
  output logic [r2a_pkg::VALUE_WIDTH-1:0] quotient_o,
  output logic [r2a_pkg::DIGIT_W-1:0]     remainder_o
);

  logic [r2a_pkg::VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [r2a_pkg::DIGIT_W-1:0]     rem_q, rem_d;
  logic [r2a_pkg::STEP_W-1:0]      cnt_q, cnt_d;
  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [r2a_pkg::DIGIT_W:0]       part;
  logic                            ge;

  // one trial subtract step
  assign part = {rem_q, quo_q[r2a_pkg::VALUE_WIDTH-1]};
  assign ge   = part >= base_i;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start || ctrl_i.cont) begin
      quo_d  = ctrl_i.start ? dividend_i : quo_q;
      rem_d  = '0;
      cnt_d  = r2a_pkg::STEP_W'(r2a_pkg::VALUE_WIDTH - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[r2a_pkg::VALUE_WIDTH-2:0], ge};
      rem_d = ge ? r2a_pkg::DIGIT_W'(part - base_i) : part[r2a_pkg::DIGIT_W-1:0];
      cnt_d = cnt_q - r2a_pkg::STEP_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state, quotient and remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      quo_q  <= quo_d;
      rem_q  <= rem_d;
    end
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

endmodule

/* src/r2a_digit_ram.sv */
// r2a_digit_ram: digit store, holds characters least significant first,
// one write and one registered read port. Depends on r2a_pkg.
module r2a_digit_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [r2a_pkg::ADDR_W-1:0] waddr_i,
  input  logic [r2a_pkg::CHAR_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [r2a_pkg::ADDR_W-1:0] raddr_i,
  output logic [r2a_pkg::CHAR_W-1:0] rdata_o
);

  logic [r2a_pkg::CHAR_W-1:0] mem_q [r2a_pkg::VALUE_WIDTH];
  logic [r2a_pkg::CHAR_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/r2a_checker.sv */
// r2a_checker: port-level assertions for the radix integer to ascii core,
// bound to the top level. Depends on r2a_pkg.
module r2a_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [r2a_pkg::CHAR_W-1:0] character_i,
  input logic                       last_char_i
);

  // a stalled character holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(character_i)
                                    && $stable(last_char_i))
    else $error("stalled output item changed");

  // an accepted item blocks the input for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after accept");

  // while text is unfinished no new number is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_char_i |-> !in_ready_i)
    else $error("input ready in the middle of a text");

  // only minus, digits and hex letters appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (character_i == r2a_pkg::CHAR_MINUS)
      || (character_i >= r2a_pkg::CHAR_ZERO && character_i <= r2a_pkg::CHAR_NINE)
      || (character_i >= r2a_pkg::CHAR_UPPER_A && character_i <= r2a_pkg::CHAR_UPPER_F)
      || (character_i >= r2a_pkg::CHAR_LOWER_A && character_i <= r2a_pkg::CHAR_LOWER_F))
    else $error("illegal output character");

endmodule

bind radix_integer_to_ascii_core r2a_checker u_r2a_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .character_i (out_o.character),
  .last_char_i (out_o.last_char)
);

/* verif/tb_radix_integer_to_ascii_core.sv */
// tb_radix_integer_to_ascii_core: self-checking testbench for the radix integer
// to ascii core; predicts the text of each number and checks every character.
// Depends on r2a_pkg, r2a_if and radix_integer_to_ascii_core.
`timescale 1ns / 100ps

module tb_radix_integer_to_ascii_core;

  // format flag codes
  localparam logic [r2a_pkg::FLAGS_W-1:0] FMT_SIGNED_UPPER   = 2'b00;
  localparam logic [r2a_pkg::FLAGS_W-1:0] FMT_UNSIGNED_UPPER = 2'b01;
  localparam logic [r2a_pkg::FLAGS_W-1:0] FMT_SIGNED_LOWER   = 2'b10;
  localparam logic [r2a_pkg::FLAGS_W-1:0] FMT_UNSIGNED_LOWER = 2'b11;

  // run control
  localparam int HOLD_CYCLES   = 600;
  localparam int QUIET_LIMIT   = 8000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int IDLE_PERCENT  = 24;
  localparam int REPORT_LIMIT  = 20;

  typedef struct packed {
    logic [r2a_pkg::CHAR_W-1:0] character;
    logic                       last_char;
  } char_item_t;

  logic clk_i;
  logic rst_ni;

  r2a_in_if  in_if ();
  r2a_out_if out_if ();

  radix_integer_to_ascii_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // text still owed by the block, oldest character first
  char_item_t  expected_text[$];
  int unsigned mismatch_count = 0;
  int unsigned numbers_sent   = 0;
  int unsigned negatives_sent = 0;
  int unsigned clamped_sent   = 0;
  int unsigned chars_checked  = 0;

  // shared with the sink process, written with nonblocking assignments
  logic        steady_mode;
  int unsigned hold_requests;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // one line per mismatch up to the report limit, every mismatch counted
  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch at %0t: %s", $time, what);
    end
  endtask

  // text of a number in the given radix, most significant character first
  function automatic void predict_text(input logic [r2a_pkg::VALUE_WIDTH-1:0] value,
                                       input logic [r2a_pkg::RADIX_W-1:0]     radix,
                                       input logic [r2a_pkg::FLAGS_W-1:0]     flags);
    string                           digit_set;
    logic [r2a_pkg::VALUE_WIDTH-1:0] quotient;
    logic [r2a_pkg::VALUE_WIDTH-1:0] base;
    logic [r2a_pkg::DIGIT_W-1:0]     digit;
    logic [r2a_pkg::CHAR_W-1:0]      text[$];
    logic                            negative;
    char_item_t                      item;
    digit_set = flags[r2a_pkg::FLAG_LOWER] ? "0123456789abcdef" : "0123456789ABCDEF";
    if (radix < r2a_pkg::RADIX_MIN) begin
      base = r2a_pkg::VALUE_WIDTH'(r2a_pkg::RADIX_MIN);
    end else if (radix > r2a_pkg::RADIX_MAX) begin
      base = r2a_pkg::VALUE_WIDTH'(r2a_pkg::RADIX_MAX);
    end else begin
      base = r2a_pkg::VALUE_WIDTH'(radix);
    end
    negative = !flags[r2a_pkg::FLAG_UNSIGNED] && value[r2a_pkg::VALUE_WIDTH-1];
    // most negative value negates to itself, which reads right as unsigned
    quotient = negative ? (~value + r2a_pkg::VALUE_WIDTH'(1)) : value;
    do begin
      digit    = r2a_pkg::DIGIT_W'(quotient % base);
      quotient = quotient / base;
      text.push_front(r2a_pkg::CHAR_W'(digit_set[digit]));
    end while (quotient != '0);
    if (negative) begin
      text.push_front(r2a_pkg::CHAR_MINUS);
    end
    while (text.size() > r2a_pkg::MAX_CHARS) begin
      void'(text.pop_back());
    end
    foreach (text[i]) begin
      item.character = text[i];
      item.last_char = (i == text.size() - 1);
      expected_text.push_back(item);
    end
  endfunction

  // present one number and wait until the block takes it
  task automatic send_number(input logic [r2a_pkg::VALUE_WIDTH-1:0] value,
                             input logic [r2a_pkg::RADIX_W-1:0]     radix,
                             input logic [r2a_pkg::FLAGS_W-1:0]     flags);
    while (!steady_mode && $urandom_range(99) < IDLE_PERCENT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.value        <= value;
    in_if.radix        <= radix;
    in_if.format_flags <= flags;
    do @(posedge clk_i); while (!in_if.ready);
    predict_text(value, radix, flags);
    numbers_sent++;
    if (!flags[r2a_pkg::FLAG_UNSIGNED] && value[r2a_pkg::VALUE_WIDTH-1]) negatives_sent++;
    if (radix < r2a_pkg::RADIX_MIN || radix > r2a_pkg::RADIX_MAX) clamped_sent++;
  endtask

  // drop valid and wait for all owed text
  task automatic finish_batch();
    in_if.valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk_i);
  endtask

  // values weighted toward small numbers and the sign boundary
  function automatic logic [r2a_pkg::VALUE_WIDTH-1:0] pick_value();
    logic [r2a_pkg::VALUE_WIDTH-1:0] v;
    case ($urandom_range(4))
      0:       v = r2a_pkg::VALUE_WIDTH'($urandom_range(999));
      1:       v = 32'h8000_0000 + r2a_pkg::VALUE_WIDTH'($urandom_range(7));
      2:       v = 32'h7FFF_FFFF - r2a_pkg::VALUE_WIDTH'($urandom_range(7));
      3:       v = '0 - r2a_pkg::VALUE_WIDTH'($urandom_range(1000));
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // mostly legal radixes, some out of range
  function automatic logic [r2a_pkg::RADIX_W-1:0] pick_radix();
    logic [r2a_pkg::RADIX_W-1:0] r;
    if ($urandom_range(9) < 7) begin
      r = r2a_pkg::RADIX_W'($urandom_range(16, 2));
    end else begin
      r = r2a_pkg::RADIX_W'($urandom_range(31, 0));
    end
    return r;
  endfunction

  // zero, all ones, most negative and largest positive in key radixes
  task automatic test_extremes();
    send_number(32'h0000_0000, 5'd10, FMT_SIGNED_UPPER);
    send_number(32'h0000_0000, 5'd2,  FMT_UNSIGNED_UPPER);
    send_number(32'hFFFF_FFFF, 5'd2,  FMT_UNSIGNED_UPPER);
    send_number(32'hFFFF_FFFF, 5'd10, FMT_SIGNED_UPPER);
    send_number(32'h8000_0000, 5'd10, FMT_SIGNED_UPPER);
    send_number(32'h8000_0000, 5'd2,  FMT_SIGNED_LOWER);
    send_number(32'h7FFF_FFFF, 5'd10, FMT_SIGNED_UPPER);
    send_number(32'hFFFF_FFFF, 5'd16, FMT_UNSIGNED_LOWER);
    send_number(32'h8000_0000, 5'd16, FMT_UNSIGNED_UPPER);
    finish_batch();
  endtask

  // radix below two and above sixteen
  task automatic test_radix_clamp();
    send_number(32'h0000_00A5, 5'd0,  FMT_UNSIGNED_UPPER);
    send_number(32'hFFFF_FF5A, 5'd1,  FMT_SIGNED_UPPER);
    send_number(32'hCAFE_F00D, 5'd17, FMT_UNSIGNED_LOWER);
    send_number(32'h8765_4321, 5'd31, FMT_SIGNED_UPPER);
    finish_batch();
  endtask

  // hex letters in both cases, odd radixes with letters
  task automatic test_letter_case();
    send_number(32'hDEAD_BEEF, 5'd16, FMT_UNSIGNED_UPPER);
    send_number(32'hDEAD_BEEF, 5'd16, FMT_UNSIGNED_LOWER);
    send_number(32'h89AB_CDEF, 5'd16, FMT_SIGNED_LOWER);
    send_number(32'd12345678,  5'd13, FMT_SIGNED_LOWER);
    send_number(32'd12345678,  5'd11, FMT_SIGNED_UPPER);
    finish_batch();
  endtask

  // random numbers, radixes and formats with idling on both sides
  task automatic test_random_numbers();
    repeat (180) begin
      send_number(pick_value(), pick_radix(), r2a_pkg::FLAGS_W'($urandom_range(3)));
    end
    finish_batch();
  endtask

  // long stretch with no idling on either side
  task automatic test_back_to_back();
    steady_mode <= 1'b1;
    repeat (30) begin
      send_number(pick_value(), pick_radix(), r2a_pkg::FLAGS_W'($urandom_range(3)));
    end
    finish_batch();
    steady_mode <= 1'b0;
  endtask

  // receiver holds off while short numbers keep coming
  task automatic test_output_backpressure();
    hold_requests <= hold_requests + 1;
    repeat (10) begin
      send_number(r2a_pkg::VALUE_WIDTH'($urandom_range(99)), 5'd10,
                  r2a_pkg::FLAGS_W'($urandom_range(3)));
    end
    finish_batch();
  endtask

  // character sink: ready pattern, hold-off and checking
  initial begin : char_sink
    int unsigned hold_left;
    int unsigned holds_served;
    char_item_t  want;
    hold_left    = 0;
    holds_served = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%02h", out_if.character));
        end else begin
          want = expected_text.pop_front();
          chars_checked++;
          if (out_if.character !== want.character) begin
            report_mismatch($sformatf("character 0x%02h, want 0x%02h",
                                      out_if.character, want.character));
          end
          if (out_if.last_char !== want.last_char) begin
            report_mismatch($sformatf("last_char %b, want %b on 0x%02h",
                                      out_if.last_char, want.last_char, want.character));
          end
        end
      end
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!rst_ni) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady_mode || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: nothing moved for %0d cycles, %0d characters owed",
             QUIET_LIMIT, expected_text.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // reset, tests in turn, verdict
  initial begin : main_sequence
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.value        <= '0;
    in_if.radix        <= '0;
    in_if.format_flags <= '0;
    steady_mode        <= 1'b0;
    hold_requests      <= 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_radix_clamp();
    test_letter_case();
    test_random_numbers();
    test_back_to_back();
    test_output_backpressure();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("converted %0d numbers (%0d negative, %0d with out-of-range radix)",
             numbers_sent, negatives_sent, clamped_sent);
    $display("checked %0d characters, %0d mismatches", chars_checked, mismatch_count);
    if (mismatch_count == 0 && expected_text.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* radix_integer_to_ascii_core.f */
src/r2a_pkg.sv
src/r2a_if.sv
src/r2a_divider.sv
src/r2a_digit_ram.sv
src/radix_integer_to_ascii_core.sv
src/r2a_checker.sv
verif/tb_radix_integer_to_ascii_core.sv
